// ----- sv/ehr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and constants for the edgel homography rectifier.
// No dependencies; used by ehr_divider and edgel_homography_rectify.
package ehr_pkg;

    // Field widths
    localparam int POS_W     = 20;
    localparam int ANG_W     = 16;
    localparam int COEF_W    = 20;
    localparam int ROW_W     = 3 * COEF_W;
    localparam int REG_IDX_W = 2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_ROW0 = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW1 = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW2 = 2'd2;

    // Parameter defaults
    localparam int CORDIC_STEPS_DEF   = 16;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // CORDIC arctangent table, pi / 2^30 units
    localparam int ATAN_TAB_LEN = 24;
    localparam logic [29:0] ATAN_TAB [ATAN_TAB_LEN] = '{
        30'd268435456, 30'd158466703, 30'd83729454, 30'd42502378,
        30'd21333666,  30'd10677233,  30'd5339919,  30'd2670123,
        30'd1335082,   30'd667543,    30'd333772,   30'd166886,
        30'd83443,     30'd41722,     30'd20861,    30'd10430,
        30'd5215,      30'd2608,      30'd1304,     30'd652,
        30'd326,       30'd163,       30'd81,       30'd41
    };

    // Sine/cosine rotator: Q30 data, angle in pi / 2^30
    localparam int SC_W         = 34;
    localparam int SZ_W         = 32;
    localparam int TRIG_W       = 16;
    localparam int SC_RND_SHIFT = 18;
    localparam logic signed [SC_W-1:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [SC_W-1:0] SC_RND   = 34'sd131072;
    localparam logic signed [SZ_W-1:0] SZ_PI    = 32'sd1073741824;
    localparam logic signed [SZ_W-1:0] SZ_HALF  = 32'sd536870912;

    // Projection datapath
    localparam int PT_W   = 34;            // point coordinate, Q.20
    localparam int PROD_W = COEF_W + PT_W;
    localparam int H_W    = 56;            // homogeneous sums
    localparam int NUM_W  = H_W + 8;       // dividend u * 256
    localparam int QUO_BITS = 42;
    localparam int Q_W      = 42;          // signed quotient, Q.8
    localparam int DIV_LAT  = QUO_BITS + 2;
    localparam logic [Q_W-1:0] QLIM = Q_W'(64'd1 << 40);
    localparam logic signed [Q_W-1:0] QPOS_MAX = Q_W'(524287);
    localparam logic signed [Q_W-1:0] QPOS_MIN = Q_W'(-524288);

    // Vectoring (atan2) datapath
    localparam int AT_W     = 48;
    localparam int AZ_W     = 34;
    localparam int NORM_LIM = 39;
    localparam logic signed [AZ_W-1:0] AZ_PI  = 34'sd1073741824;
    localparam logic signed [AZ_W-1:0] AZ_RND = 34'sd16384;

    // Divider result
    typedef struct packed {
        logic signed [Q_W-1:0] q;
        logic                  err;
    } div_res_t;

    // Side data riding along the angle pipeline
    typedef struct packed {
        logic                    kind;
        logic                    err;
        logic                    deg;
        logic signed [POS_W-1:0] qx;
        logic signed [POS_W-1:0] qy;
    } tail_t;

endpackage

// ----- sv/ehr_divider.sv -----
`timescale 1ns / 1ps
// Pipelined signed divider: (u * 256) / w truncated, clamped to +-2^40.
// One quotient bit per stage; depends on ehr_pkg.
module ehr_divider (
    input  logic                         clk,
    input  logic signed [ehr_pkg::H_W-1:0] u,
    input  logic signed [ehr_pkg::H_W-1:0] w,
    output ehr_pkg::div_res_t            res
);

    localparam int HW = ehr_pkg::H_W;
    localparam int QB = ehr_pkg::QUO_BITS;
    localparam int NW = ehr_pkg::NUM_W;

    typedef struct packed {
        logic neg;    // quotient sign
        logic wzero;
        logic upos;
        logic unz;
        logic ovf;    // quotient needs more than QB bits
    } dctl_t;

    logic [HW-1:0] d_rem_reg [QB+1];
    logic [QB-1:0] d_low_reg [QB+1];
    logic [QB-1:0] d_quo_reg [QB+1];
    logic [HW-1:0] d_den_reg [QB+1];
    dctl_t         d_ctl_reg [QB+1];
    ehr_pkg::div_res_t res_reg;

    logic [HW-1:0] u_mag;
    logic [HW-1:0] w_mag;
    logic [NW-1:0] num;

    // Magnitudes and overflow check
    always_comb
    begin
        u_mag = u[HW-1] ? HW'(-u) : HW'(u);
        w_mag = w[HW-1] ? HW'(-w) : HW'(w);
        num   = {u_mag, 8'd0};
    end

    always_ff @(posedge clk)
    begin
        d_rem_reg[0]       <= HW'(num[NW-1:QB]);
        d_low_reg[0]       <= num[QB-1:0];
        d_quo_reg[0]       <= '0;
        d_den_reg[0]       <= w_mag;
        d_ctl_reg[0].neg   <= u[HW-1] ^ w[HW-1];
        d_ctl_reg[0].wzero <= (w == '0);
        d_ctl_reg[0].upos  <= !u[HW-1];
        d_ctl_reg[0].unz   <= (u != '0);
        d_ctl_reg[0].ovf   <= (HW'(num[NW-1:QB]) >= w_mag);
    end

    // Restoring steps, one quotient bit each
    for (genvar k = 1; k <= QB; k++)
    begin : g_step
        logic [HW:0]   shifted;
        logic [HW+1:0] trial;
        logic          ge;

        always_comb
        begin
            shifted = {d_rem_reg[k-1], d_low_reg[k-1][QB-1]};
            trial   = {1'b0, shifted} - {2'b00, d_den_reg[k-1]};
            ge      = !trial[HW+1];
        end

        always_ff @(posedge clk)
        begin
            d_rem_reg[k] <= ge ? trial[HW-1:0] : shifted[HW-1:0];
            d_low_reg[k] <= {d_low_reg[k-1][QB-2:0], 1'b0};
            d_quo_reg[k] <= {d_quo_reg[k-1][QB-2:0], ge};
            d_den_reg[k] <= d_den_reg[k-1];
            d_ctl_reg[k] <= d_ctl_reg[k-1];
        end
    end

    // Sign, saturation and zero-w handling
    always_ff @(posedge clk)
    begin
        if (d_ctl_reg[QB].wzero)
        begin
            res_reg.err <= 1'b1;
            if (!d_ctl_reg[QB].unz)
                res_reg.q <= '0;
            else if (d_ctl_reg[QB].upos)
                res_reg.q <= $signed(ehr_pkg::QLIM);
            else
                res_reg.q <= -$signed(ehr_pkg::QLIM);
        end
        else if (d_ctl_reg[QB].ovf || (d_quo_reg[QB] > ehr_pkg::QLIM))
        begin
            res_reg.err <= 1'b1;
            res_reg.q   <= d_ctl_reg[QB].neg ? -$signed(ehr_pkg::QLIM)
                                             : $signed(ehr_pkg::QLIM);
        end
        else
        begin
            res_reg.err <= 1'b0;
            res_reg.q   <= d_ctl_reg[QB].neg ? -$signed(d_quo_reg[QB])
                                             : $signed(d_quo_reg[QB]);
        end
    end

    assign res = res_reg;

endmodule

// ----- sv/edgel_homography_rectify.sv -----
`timescale 1ns / 1ps
// Edgel homography rectifier: maps an edge position through a 3x3
// homography and recomputes its orientation. Depends on ehr_pkg, ehr_divider.
//
// Use: write the three matrix rows through wr_en / wr_index / wr_data while
// no word is in flight; they reset to the identity. Present a word on
// pos_x, pos_y, angle, kind with start high; it is taken at any edge where
// busy is low, and busy never rises, so a word can enter every cycle.
// Each result shows on out_x, out_y, out_angle, rectified_mark and
// range_error for one cycle with done high. One word per cycle
// sustained: every step (sine/cosine rotator, multipliers, six
// bit-per-stage dividers, normalizer, atan2 rotator) is pipelined.
// The result side cannot hold off results. Reset clears all valid bits and
// restores the identity matrix; words in flight are dropped.
module edgel_homography_rectify #(
    parameter int CORDIC_STEPS   = ehr_pkg::CORDIC_STEPS_DEF,
    parameter int COEF_FRAC_BITS = ehr_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [ehr_pkg::REG_IDX_W-1:0]       wr_index,
    input  logic [ehr_pkg::ROW_W-1:0]           wr_data,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [ehr_pkg::POS_W-1:0]    pos_x,
    input  logic signed [ehr_pkg::POS_W-1:0]    pos_y,
    input  logic signed [ehr_pkg::ANG_W-1:0]    angle,
    input  logic                                kind,
    output logic                                done,
    output logic signed [ehr_pkg::POS_W-1:0]    out_x,
    output logic signed [ehr_pkg::POS_W-1:0]    out_y,
    output logic signed [ehr_pkg::ANG_W-1:0]    out_angle,
    output logic                                rectified_mark,
    output logic                                range_error
);

    localparam int N       = CORDIC_STEPS;
    localparam int LAT_CHK = 2 * CORDIC_STEPS + 54;
    localparam int CW      = ehr_pkg::COEF_W;
    localparam int P_CTR   = 0;
    localparam int P_AHEAD = 1;
    localparam int P_BACK  = 2;

    localparam logic [CW-1:0] ONE_COEF = CW'(64'd1 << COEF_FRAC_BITS);
    localparam logic [ehr_pkg::ROW_W-1:0] ROW0_RST = ehr_pkg::ROW_W'(ONE_COEF);
    localparam logic [ehr_pkg::ROW_W-1:0] ROW1_RST = ehr_pkg::ROW_W'(ONE_COEF) << CW;
    localparam logic [ehr_pkg::ROW_W-1:0] ROW2_RST = ehr_pkg::ROW_W'(ONE_COEF) << (2 * CW);

    function automatic logic in_range(input logic signed [ehr_pkg::AT_W-1:0] v,
                                      input int k);
        logic signed [ehr_pkg::AT_W-1:0] lim;
        lim = ehr_pkg::AT_W'(64'sd1 <<< k);
        return (v < lim) && (v > -lim);
    endfunction

    // ------------------------------------------------------------------
    // Matrix registers
    logic [ehr_pkg::ROW_W-1:0] matrix_reg [3];
    logic signed [CW-1:0]      coef_w [3][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg[0] <= ROW0_RST;
            matrix_reg[1] <= ROW1_RST;
            matrix_reg[2] <= ROW2_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                ehr_pkg::REG_ROW0: matrix_reg[0] <= wr_data;
                ehr_pkg::REG_ROW1: matrix_reg[1] <= wr_data;
                ehr_pkg::REG_ROW2: matrix_reg[2] <= wr_data;
                default: ;
            endcase
        end
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_coef_r
        for (genvar c = 0; c < 3; c++)
        begin : g_coef_c
            assign coef_w[r][c] = matrix_reg[r][c*CW +: CW];
        end
    end

    // Always ready
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Entry: fold angle into +-pi/2
    logic signed [ehr_pkg::SZ_W-1:0] z_raw;
    logic signed [ehr_pkg::SZ_W-1:0] z_fold;
    logic                            neg_fold;

    always_comb
    begin
        z_raw    = ehr_pkg::SZ_W'(angle) <<< 15;
        z_fold   = z_raw;
        neg_fold = 1'b0;
        if (z_raw > ehr_pkg::SZ_HALF)
        begin
            z_fold   = z_raw - ehr_pkg::SZ_PI;
            neg_fold = 1'b1;
        end
        else if (z_raw < -ehr_pkg::SZ_HALF)
        begin
            z_fold   = z_raw + ehr_pkg::SZ_PI;
            neg_fold = 1'b1;
        end
    end

    logic signed [ehr_pkg::SC_W-1:0]  sc_x_reg    [N+1];
    logic signed [ehr_pkg::SC_W-1:0]  sc_y_reg    [N+1];
    logic signed [ehr_pkg::SZ_W-1:0]  sc_z_reg    [N+1];
    logic                             sc_neg_reg  [N+1];
    logic signed [ehr_pkg::POS_W-1:0] sc_px_reg   [N+1];
    logic signed [ehr_pkg::POS_W-1:0] sc_py_reg   [N+1];
    logic                             sc_kind_reg [N+1];
    logic                             sc_vld_reg  [N+1];

    always_ff @(posedge clk)
    begin
        sc_x_reg[0]    <= ehr_pkg::GAIN_Q30;
        sc_y_reg[0]    <= '0;
        sc_z_reg[0]    <= z_fold;
        sc_neg_reg[0]  <= neg_fold;
        sc_px_reg[0]   <= pos_x;
        sc_py_reg[0]   <= pos_y;
        sc_kind_reg[0] <= kind;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sc_vld_reg[0] <= 1'b0;
        else
            sc_vld_reg[0] <= start && !busy;
    end

    // Rotation-mode CORDIC, one iteration per stage
    for (genvar i = 0; i < N; i++)
    begin : g_sc
        localparam logic signed [ehr_pkg::SZ_W-1:0] AT_I =
            ehr_pkg::SZ_W'(ehr_pkg::ATAN_TAB[i]);

        always_ff @(posedge clk)
        begin
            if (sc_z_reg[i] >= 0)
            begin
                sc_x_reg[i+1] <= sc_x_reg[i] - (sc_y_reg[i] >>> i);
                sc_y_reg[i+1] <= sc_y_reg[i] + (sc_x_reg[i] >>> i);
                sc_z_reg[i+1] <= sc_z_reg[i] - AT_I;
            end
            else
            begin
                sc_x_reg[i+1] <= sc_x_reg[i] + (sc_y_reg[i] >>> i);
                sc_y_reg[i+1] <= sc_y_reg[i] - (sc_x_reg[i] >>> i);
                sc_z_reg[i+1] <= sc_z_reg[i] + AT_I;
            end
            sc_neg_reg[i+1]  <= sc_neg_reg[i];
            sc_px_reg[i+1]   <= sc_px_reg[i];
            sc_py_reg[i+1]   <= sc_py_reg[i];
            sc_kind_reg[i+1] <= sc_kind_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sc_vld_reg[i+1] <= 1'b0;
            else
                sc_vld_reg[i+1] <= sc_vld_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // Round to Q12 and form the three points
    logic signed [ehr_pkg::SC_W-1:0]   c_sum;
    logic signed [ehr_pkg::SC_W-1:0]   s_sum;
    logic signed [ehr_pkg::TRIG_W-1:0] c_rnd;
    logic signed [ehr_pkg::TRIG_W-1:0] s_rnd;
    logic signed [ehr_pkg::PT_W-1:0]   x_ctr;
    logic signed [ehr_pkg::PT_W-1:0]   y_ctr;
    logic signed [ehr_pkg::PT_W-1:0]   x_off;
    logic signed [ehr_pkg::PT_W-1:0]   y_off;

    always_comb
    begin
        c_sum = sc_x_reg[N] + ehr_pkg::SC_RND;
        s_sum = sc_y_reg[N] + ehr_pkg::SC_RND;
        c_rnd = ehr_pkg::TRIG_W'(c_sum >>> ehr_pkg::SC_RND_SHIFT);
        s_rnd = ehr_pkg::TRIG_W'(s_sum >>> ehr_pkg::SC_RND_SHIFT);
        if (sc_neg_reg[N])
        begin
            c_rnd = -c_rnd;
            s_rnd = -s_rnd;
        end
        x_ctr = ehr_pkg::PT_W'(sc_px_reg[N]) <<< 12;
        y_ctr = ehr_pkg::PT_W'(sc_py_reg[N]) <<< 12;
        x_off = ehr_pkg::PT_W'(c_rnd) <<< 8;
        y_off = ehr_pkg::PT_W'(s_rnd) <<< 8;
    end

    logic signed [ehr_pkg::PT_W-1:0] pt_x_reg [3];
    logic signed [ehr_pkg::PT_W-1:0] pt_y_reg [3];
    logic                            pt_kind_reg;
    logic                            pt_vld_reg;

    always_ff @(posedge clk)
    begin
        pt_x_reg[P_CTR]   <= x_ctr;
        pt_y_reg[P_CTR]   <= y_ctr;
        pt_x_reg[P_AHEAD] <= x_ctr + x_off;
        pt_y_reg[P_AHEAD] <= y_ctr + y_off;
        pt_x_reg[P_BACK]  <= x_ctr - x_off;
        pt_y_reg[P_BACK]  <= y_ctr - y_off;
        pt_kind_reg       <= sc_kind_reg[N];
    end

    // ------------------------------------------------------------------
    // Products, then homogeneous sums
    logic signed [ehr_pkg::PROD_W-1:0] mx_reg [3][3];
    logic signed [ehr_pkg::PROD_W-1:0] my_reg [3][3];
    logic                              m_kind_reg;
    logic                              m_vld_reg;
    logic signed [ehr_pkg::H_W-1:0]    h_reg [3][3];
    logic                              h_kind_reg;
    logic                              h_vld_reg;

    for (genvar p = 0; p < 3; p++)
    begin : g_pt
        for (genvar r = 0; r < 3; r++)
        begin : g_row
            always_ff @(posedge clk)
            begin
                mx_reg[p][r] <= coef_w[r][0] * pt_x_reg[p];
                my_reg[p][r] <= coef_w[r][1] * pt_y_reg[p];
                h_reg[p][r]  <= ehr_pkg::H_W'(mx_reg[p][r]) + ehr_pkg::H_W'(my_reg[p][r])
                              + (ehr_pkg::H_W'(coef_w[r][2]) <<< 20);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        m_kind_reg <= pt_kind_reg;
        h_kind_reg <= m_kind_reg;
    end

    // ------------------------------------------------------------------
    // Six dividers: u/w and v/w for each point
    ehr_pkg::div_res_t div_res [6];

    for (genvar p = 0; p < 3; p++)
    begin : g_div_p
        for (genvar k = 0; k < 2; k++)
        begin : g_div_k
            ehr_divider u_div (
                .clk (clk),
                .u   (h_reg[p][k]),
                .w   (h_reg[p][2]),
                .res (div_res[p*2+k])
            );
        end
    end

    logic dl_kind_reg [ehr_pkg::DIV_LAT];
    logic dl_vld_reg  [ehr_pkg::DIV_LAT];

    always_ff @(posedge clk)
    begin
        dl_kind_reg[0] <= h_kind_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dl_vld_reg[0] <= 1'b0;
        else
            dl_vld_reg[0] <= h_vld_reg;
    end

    for (genvar d = 1; d < ehr_pkg::DIV_LAT; d++)
    begin : g_dl
        always_ff @(posedge clk)
        begin
            dl_kind_reg[d] <= dl_kind_reg[d-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dl_vld_reg[d] <= 1'b0;
            else
                dl_vld_reg[d] <= dl_vld_reg[d-1];
        end
    end

    // Valid chain through points, products and sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pt_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
            h_vld_reg  <= 1'b0;
        end
        else
        begin
            pt_vld_reg <= sc_vld_reg[N];
            m_vld_reg  <= pt_vld_reg;
            h_vld_reg  <= m_vld_reg;
        end
    end

    // ------------------------------------------------------------------
    // Clamp position, form direction vector
    logic signed [ehr_pkg::Q_W-1:0]  qx_c;
    logic signed [ehr_pkg::Q_W-1:0]  qy_c;
    logic signed [ehr_pkg::AT_W-1:0] dx;
    logic signed [ehr_pkg::AT_W-1:0] dy;
    logic                            post_err;

    always_comb
    begin
        post_err = div_res[0].err | div_res[1].err | div_res[2].err
                 | div_res[3].err | div_res[4].err | div_res[5].err;
        qx_c = div_res[0].q;
        qy_c = div_res[1].q;
        if (qx_c > ehr_pkg::QPOS_MAX)
        begin
            qx_c     = ehr_pkg::QPOS_MAX;
            post_err = 1'b1;
        end
        else if (qx_c < ehr_pkg::QPOS_MIN)
        begin
            qx_c     = ehr_pkg::QPOS_MIN;
            post_err = 1'b1;
        end
        if (qy_c > ehr_pkg::QPOS_MAX)
        begin
            qy_c     = ehr_pkg::QPOS_MAX;
            post_err = 1'b1;
        end
        else if (qy_c < ehr_pkg::QPOS_MIN)
        begin
            qy_c     = ehr_pkg::QPOS_MIN;
            post_err = 1'b1;
        end
        dx = ehr_pkg::AT_W'(div_res[2].q) - ehr_pkg::AT_W'(div_res[4].q);
        dy = ehr_pkg::AT_W'(div_res[3].q) - ehr_pkg::AT_W'(div_res[5].q);
    end

    // Normalizer: greedy shift search, two steps per stage
    logic signed [ehr_pkg::AT_W-1:0] nm_x_reg    [4];
    logic signed [ehr_pkg::AT_W-1:0] nm_y_reg    [4];
    logic                            nm_out_reg  [4];
    ehr_pkg::tail_t                  nm_tail_reg [4];
    logic                            nm_vld_reg  [4];

    always_ff @(posedge clk)
    begin
        nm_x_reg[0]         <= dx;
        nm_y_reg[0]         <= dy;
        nm_out_reg[0]       <= !(in_range(dx, ehr_pkg::NORM_LIM)
                                 && in_range(dy, ehr_pkg::NORM_LIM));
        nm_tail_reg[0].kind <= dl_kind_reg[ehr_pkg::DIV_LAT-1];
        nm_tail_reg[0].err  <= post_err;
        nm_tail_reg[0].deg  <= (dx == '0) && (dy == '0);
        nm_tail_reg[0].qx   <= ehr_pkg::POS_W'(qx_c);
        nm_tail_reg[0].qy   <= ehr_pkg::POS_W'(qy_c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nm_vld_reg[0] <= 1'b0;
        else
            nm_vld_reg[0] <= dl_vld_reg[ehr_pkg::DIV_LAT-1];
    end

    for (genvar g = 0; g < 3; g++)
    begin : g_nm
        localparam int SA = 1 << (5 - 2 * g);
        localparam int SB = 1 << (4 - 2 * g);
        logic signed [ehr_pkg::AT_W-1:0] x_a;
        logic signed [ehr_pkg::AT_W-1:0] y_a;
        logic signed [ehr_pkg::AT_W-1:0] x_b;
        logic signed [ehr_pkg::AT_W-1:0] y_b;

        always_comb
        begin
            x_a = nm_x_reg[g];
            y_a = nm_y_reg[g];
            if (in_range(x_a, ehr_pkg::NORM_LIM - SA) && in_range(y_a, ehr_pkg::NORM_LIM - SA))
            begin
                x_a = x_a <<< SA;
                y_a = y_a <<< SA;
            end
            x_b = x_a;
            y_b = y_a;
            if (in_range(x_b, ehr_pkg::NORM_LIM - SB) && in_range(y_b, ehr_pkg::NORM_LIM - SB))
            begin
                x_b = x_b <<< SB;
                y_b = y_b <<< SB;
            end
        end

        always_ff @(posedge clk)
        begin
            nm_x_reg[g+1]    <= x_b;
            nm_y_reg[g+1]    <= y_b;
            nm_out_reg[g+1]  <= nm_out_reg[g];
            nm_tail_reg[g+1] <= nm_tail_reg[g];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                nm_vld_reg[g+1] <= 1'b0;
            else
                nm_vld_reg[g+1] <= nm_vld_reg[g];
        end
    end

    // Last doubling, then fold the left half-plane by pi
    logic signed [ehr_pkg::AT_W-1:0] f_x;
    logic signed [ehr_pkg::AT_W-1:0] f_y;
    logic signed [ehr_pkg::AZ_W-1:0] f_z;

    always_comb
    begin
        f_x = nm_x_reg[3];
        f_y = nm_y_reg[3];
        if (!nm_out_reg[3])
        begin
            f_x = f_x <<< 1;
            f_y = f_y <<< 1;
        end
        f_z = '0;
        if (f_x < 0)
        begin
            f_z = (f_y >= 0) ? ehr_pkg::AZ_PI : -ehr_pkg::AZ_PI;
            f_x = -f_x;
            f_y = -f_y;
        end
    end

    // ------------------------------------------------------------------
    // Vectoring-mode CORDIC for atan2
    logic signed [ehr_pkg::AT_W-1:0] at_x_reg    [N+1];
    logic signed [ehr_pkg::AT_W-1:0] at_y_reg    [N+1];
    logic signed [ehr_pkg::AZ_W-1:0] at_z_reg    [N+1];
    ehr_pkg::tail_t                  at_tail_reg [N+1];
    logic                            at_vld_reg  [N+1];

    always_ff @(posedge clk)
    begin
        at_x_reg[0]    <= f_x;
        at_y_reg[0]    <= f_y;
        at_z_reg[0]    <= f_z;
        at_tail_reg[0] <= nm_tail_reg[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            at_vld_reg[0] <= 1'b0;
        else
            at_vld_reg[0] <= nm_vld_reg[3];
    end

    for (genvar i = 0; i < N; i++)
    begin : g_at
        localparam logic signed [ehr_pkg::AZ_W-1:0] AT_I =
            ehr_pkg::AZ_W'(ehr_pkg::ATAN_TAB[i]);

        always_ff @(posedge clk)
        begin
            if (at_y_reg[i] > 0)
            begin
                at_x_reg[i+1] <= at_x_reg[i] + (at_y_reg[i] >>> i);
                at_y_reg[i+1] <= at_y_reg[i] - (at_x_reg[i] >>> i);
                at_z_reg[i+1] <= at_z_reg[i] + AT_I;
            end
            else
            begin
                at_x_reg[i+1] <= at_x_reg[i] - (at_y_reg[i] >>> i);
                at_y_reg[i+1] <= at_y_reg[i] + (at_x_reg[i] >>> i);
                at_z_reg[i+1] <= at_z_reg[i] - AT_I;
            end
            at_tail_reg[i+1] <= at_tail_reg[i];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                at_vld_reg[i+1] <= 1'b0;
            else
                at_vld_reg[i+1] <= at_vld_reg[i];
        end
    end

    // ------------------------------------------------------------------
    // Output word
    logic signed [ehr_pkg::AZ_W-1:0]  z_rnd;
    logic                             done_reg;
    logic signed [ehr_pkg::POS_W-1:0] out_x_reg;
    logic signed [ehr_pkg::POS_W-1:0] out_y_reg;
    logic signed [ehr_pkg::ANG_W-1:0] out_angle_reg;
    logic                             mark_reg;
    logic                             err_reg;

    assign z_rnd = at_z_reg[N] + ehr_pkg::AZ_RND;

    always_ff @(posedge clk)
    begin
        out_x_reg     <= at_tail_reg[N].qx;
        out_y_reg     <= at_tail_reg[N].qy;
        out_angle_reg <= at_tail_reg[N].deg ? '0 : z_rnd[30:15];
        mark_reg      <= !at_tail_reg[N].kind;
        err_reg       <= at_tail_reg[N].err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= at_vld_reg[N];
    end

    assign done           = done_reg;
    assign out_x          = out_x_reg;
    assign out_y          = out_y_reg;
    assign out_angle      = out_angle_reg;
    assign rectified_mark = mark_reg;
    assign range_error    = err_reg;

    // ------------------------------------------------------------------
    // Checks
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT_CHK))
        else $error("result word without a matching input word");

    a_mark_follows_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rectified_mark == !$past(kind, LAT_CHK)))
        else $error("rectified mark out of step with its input word");

    a_bad_index_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && wr_index != ehr_pkg::REG_ROW0 && wr_index != ehr_pkg::REG_ROW1
         && wr_index != ehr_pkg::REG_ROW2)
        |=> ($stable(matrix_reg[0]) && $stable(matrix_reg[1]) && $stable(matrix_reg[2])))
        else $error("write to unused index changed the matrix");

endmodule
